// File: design/assert_macros.svh
// Assertion macros used by the circle engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// File: design/cftp_pkg.sv
// Widths, constants and stage types of the circle-through-three-points engine.
package cftp_pkg;

	localparam int CW   = 16;          // coordinate width, Q12.4 (exact up to 20)
	localparam int DW   = CW + 1;      // coordinate difference
	localparam int PW   = 2 * DW;      // signed product of two differences
	localparam int LW   = 2 * CW + 1;  // squared side length
	localparam int DETW = PW + 2;      // determinant, signed
	localparam int DMW  = DETW - 1;    // determinant magnitude
	localparam int NW   = DW + LW + 2; // numerator, signed
	localparam int NMW  = NW - 1;      // numerator magnitude
	localparam int QB   = 26;          // quotient bits resolved by the divider
	localparam int QW   = QB + 1;      // rounded quotient
	localparam int CMPW = DMW + QB + 1;
	localparam int CXW  = QW + 2;      // unclamped centre
	localparam int OW   = 24;          // result width
	localparam int SW   = 2 * OW + 1;  // sum of squared offsets
	localparam int RB   = (SW + 1) / 2;// root bits
	localparam int TW   = 2 * RB + 1;  // root trial / remainder
	localparam int MCW  = 35;          // min_cross register

	localparam int LAT  = 10 + 1 + QB + 3 + RB + 1;

	localparam logic [MCW-1:0]       MIN_CROSS_RST = MCW'(1);
	localparam logic signed [CXW-1:0] SAT_POS = CXW'(8388607);
	localparam logic signed [CXW-1:0] SAT_NEG = -CXW'(8388608);
	localparam logic [QW-1:0]        OUT_MAX_Q = QW'(24'hFFFFFF);
	localparam logic [RB:0]          OUT_MAX_R = (RB+1)'(24'hFFFFFF);

	// pivot choice: which side is longest
	localparam logic [1:0] SEL_S12 = 2'd0;
	localparam logic [1:0] SEL_S23 = 2'd1;
	localparam logic [1:0] SEL_S31 = 2'd2;

	typedef struct packed {
		logic                 coll;
		logic                 negx;
		logic                 negy;
		logic                 ovfx;
		logic                 ovfy;
		logic signed [CW-1:0] mx;
		logic signed [CW-1:0] my;
	} dv_side_t;

	typedef struct packed {
		logic                 coll;
		logic                 satc;
		logic                 radsat;
		logic signed [OW-1:0] cenx;
		logic signed [OW-1:0] ceny;
	} sq_side_t;

endpackage

// File: design/circle_from_three_points_top.sv
// Circle engine top level: circumcircle of three Q12.4 points, fully pipelined.
// Throughput: one word per cycle; busy never rises, so start may be held high.
// Cost sits in the restoring divider (one quotient bit per stage, 26 stages)
// and the root extractor (one root bit per stage, 25 stages).
// Reset clears the valid bits and loads min_cross with 1; data registers are not reset.
`include "assert_macros.svh"

module circle_from_three_points_top import cftp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic signed [CW-1:0] first_x,
	input  logic signed [CW-1:0] first_y,
	input  logic signed [CW-1:0] second_x,
	input  logic signed [CW-1:0] second_y,
	input  logic signed [CW-1:0] third_x,
	input  logic signed [CW-1:0] third_y,
	output logic                 done,
	output logic signed [OW-1:0] center_x,
	output logic signed [OW-1:0] center_y,
	output logic        [OW-1:0] radius,
	output logic                 valid_res,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic        [MCW-1:0] cfg_data
);

	// The pipeline never stalls, so take a word every cycle and take
	// configuration whenever it comes.
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	logic [MCW-1:0] min_cross_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_cross_q <= MIN_CROSS_RST;
		end else if (cfg_valid && cfg_ready) begin
			min_cross_q <= cfg_data;
		end
	end

	// ------------------------------------------------------------------
	// Valid bits travel alongside the data
	// ------------------------------------------------------------------
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9, vld_s10;
	logic vld_sdv [0:QB];
	logic vld_sr, vld_sc;
	logic vld_ssq [0:RB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0; vld_s2 <= 1'b0; vld_s3 <= 1'b0; vld_s4 <= 1'b0;
			vld_s5 <= 1'b0; vld_s6 <= 1'b0; vld_s7 <= 1'b0; vld_s8 <= 1'b0;
			vld_s9 <= 1'b0; vld_s10 <= 1'b0;
			for (int k = 0; k <= QB; k++) vld_sdv[k] <= 1'b0;
			vld_sr <= 1'b0;
			vld_sc <= 1'b0;
			for (int k = 0; k <= RB; k++) vld_ssq[k] <= 1'b0;
			done <= 1'b0;
		end else begin
			vld_s1  <= start && !busy;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_sdv[0] <= vld_s10;
			for (int k = 1; k <= QB; k++) vld_sdv[k] <= vld_sdv[k-1];
			vld_sr <= vld_sdv[QB];
			vld_sc <= vld_sr;
			vld_ssq[0] <= vld_sc;
			for (int k = 1; k <= RB; k++) vld_ssq[k] <= vld_ssq[k-1];
			done <= vld_ssq[RB];
		end
	end

	// ------------------------------------------------------------------
	// Front end: side lengths, pivot choice, determinant and numerators
	// ------------------------------------------------------------------
	logic signed [CW-1:0]  px_s1 [0:2], py_s1 [0:2];
	logic signed [CW-1:0]  px_s2 [0:2], py_s2 [0:2];
	logic signed [DW-1:0]  dx_s2 [0:2], dy_s2 [0:2];
	logic signed [CW-1:0]  px_s3 [0:2], py_s3 [0:2];
	logic signed [PW-1:0]  sx_s3 [0:2], sy_s3 [0:2];
	logic signed [CW-1:0]  px_s4 [0:2], py_s4 [0:2];
	logic        [LW-1:0]  len_s4 [0:2];
	logic signed [DW-1:0]  ax_s5, ay_s5, cx_s5, cy_s5;
	logic signed [CW-1:0]  mx_s5, my_s5;
	logic signed [DW-1:0]  ax_s6, ay_s6, cx_s6, cy_s6;
	logic signed [CW-1:0]  mx_s6, my_s6;
	logic signed [PW-1:0]  pacy_s6, payc_s6, sax_s6, say_s6, scx_s6, scy_s6;
	logic signed [DW-1:0]  ax_s7, ay_s7, cx_s7, cy_s7;
	logic signed [CW-1:0]  mx_s7, my_s7;
	logic signed [DETW-1:0] det_s7;
	logic        [LW-1:0]  la_s7, lc_s7;
	logic signed [CW-1:0]  mx_s8, my_s8;
	logic        [DMW-1:0] dm_s8;
	logic                  dneg_s8;
	logic signed [NW-2:0]  cyla_s8, aylc_s8, axlc_s8, cxla_s8;
	logic signed [CW-1:0]  mx_s9, my_s9;
	logic        [DMW-1:0] dm_s9;
	logic                  dneg_s9, coll_s9;
	logic signed [NW-1:0]  nx_s9, ny_s9;
	logic signed [CW-1:0]  mx_s10, my_s10;
	logic        [DMW-1:0] dm_s10;
	logic                  coll_s10, negx_s10, negy_s10;
	logic        [NMW-1:0] nmx_s10, nmy_s10;

	logic [1:0]           sel_c;
	logic signed [DW-1:0] ax_c, ay_c, cx_c, cy_c;
	logic signed [CW-1:0] mx_c, my_c;

	// Pick the pivot opposite the longest side; ties keep the earlier side.
	always_comb begin
		sel_c = SEL_S12;
		if (len_s4[1] > len_s4[0]) begin
			sel_c = SEL_S23;
		end
		if (len_s4[2] > ((sel_c == SEL_S23) ? len_s4[1] : len_s4[0])) begin
			sel_c = SEL_S31;
		end
	end

	always_comb begin
		unique case (sel_c)
			SEL_S23: begin
				ax_c = DW'(px_s4[1]) - DW'(px_s4[0]);
				ay_c = DW'(py_s4[1]) - DW'(py_s4[0]);
				cx_c = DW'(px_s4[2]) - DW'(px_s4[0]);
				cy_c = DW'(py_s4[2]) - DW'(py_s4[0]);
				mx_c = px_s4[0];
				my_c = py_s4[0];
			end
			SEL_S31: begin
				ax_c = DW'(px_s4[2]) - DW'(px_s4[1]);
				ay_c = DW'(py_s4[2]) - DW'(py_s4[1]);
				cx_c = DW'(px_s4[0]) - DW'(px_s4[1]);
				cy_c = DW'(py_s4[0]) - DW'(py_s4[1]);
				mx_c = px_s4[1];
				my_c = py_s4[1];
			end
			default: begin
				ax_c = DW'(px_s4[0]) - DW'(px_s4[2]);
				ay_c = DW'(py_s4[0]) - DW'(py_s4[2]);
				cx_c = DW'(px_s4[1]) - DW'(px_s4[2]);
				cy_c = DW'(py_s4[1]) - DW'(py_s4[2]);
				mx_c = px_s4[2];
				my_c = py_s4[2];
			end
		endcase
	end

	always_ff @(posedge clk) begin
		// register the three points
		px_s1[0] <= first_x;  py_s1[0] <= first_y;
		px_s1[1] <= second_x; py_s1[1] <= second_y;
		px_s1[2] <= third_x;  py_s1[2] <= third_y;

		// side vectors 1-2, 2-3, 3-1
		for (int i = 0; i < 3; i++) begin
			dx_s2[i] <= DW'(px_s1[(i+1)%3]) - DW'(px_s1[i]);
			dy_s2[i] <= DW'(py_s1[(i+1)%3]) - DW'(py_s1[i]);
			px_s2[i] <= px_s1[i];
			py_s2[i] <= py_s1[i];
		end

		for (int i = 0; i < 3; i++) begin
			sx_s3[i] <= dx_s2[i] * dx_s2[i];
			sy_s3[i] <= dy_s2[i] * dy_s2[i];
			px_s3[i] <= px_s2[i];
			py_s3[i] <= py_s2[i];
		end

		for (int i = 0; i < 3; i++) begin
			len_s4[i] <= LW'(sx_s3[i] + sy_s3[i]);
			px_s4[i]  <= px_s3[i];
			py_s4[i]  <= py_s3[i];
		end

		ax_s5 <= ax_c; ay_s5 <= ay_c; cx_s5 <= cx_c; cy_s5 <= cy_c;
		mx_s5 <= mx_c; my_s5 <= my_c;

		pacy_s6 <= ax_s5 * cy_s5;
		payc_s6 <= ay_s5 * cx_s5;
		sax_s6  <= ax_s5 * ax_s5;
		say_s6  <= ay_s5 * ay_s5;
		scx_s6  <= cx_s5 * cx_s5;
		scy_s6  <= cy_s5 * cy_s5;
		ax_s6 <= ax_s5; ay_s6 <= ay_s5; cx_s6 <= cx_s5; cy_s6 <= cy_s5;
		mx_s6 <= mx_s5; my_s6 <= my_s5;

		det_s7 <= {(PW+1)'(pacy_s6) - (PW+1)'(payc_s6), 1'b0};
		la_s7  <= LW'(sax_s6 + say_s6);
		lc_s7  <= LW'(scx_s6 + scy_s6);
		ax_s7 <= ax_s6; ay_s7 <= ay_s6; cx_s7 <= cx_s6; cy_s7 <= cy_s6;
		mx_s7 <= mx_s6; my_s7 <= my_s6;

		dm_s8   <= DMW'(det_s7[DETW-1] ? -det_s7 : det_s7);
		dneg_s8 <= det_s7[DETW-1];
		cyla_s8 <= cy_s7 * $signed({1'b0, la_s7});
		aylc_s8 <= ay_s7 * $signed({1'b0, lc_s7});
		axlc_s8 <= ax_s7 * $signed({1'b0, lc_s7});
		cxla_s8 <= cx_s7 * $signed({1'b0, la_s7});
		mx_s8 <= mx_s7; my_s8 <= my_s7;

		nx_s9   <= NW'(cyla_s8) - NW'(aylc_s8);
		ny_s9   <= NW'(axlc_s8) - NW'(cxla_s8);
		coll_s9 <= (dm_s8 == '0) || (dm_s8 < min_cross_q);
		dm_s9   <= dm_s8;
		dneg_s9 <= dneg_s8;
		mx_s9 <= mx_s8; my_s9 <= my_s8;

		nmx_s10  <= NMW'(nx_s9[NW-1] ? -nx_s9 : nx_s9);
		nmy_s10  <= NMW'(ny_s9[NW-1] ? -ny_s9 : ny_s9);
		negx_s10 <= nx_s9[NW-1] ^ dneg_s9;
		negy_s10 <= ny_s9[NW-1] ^ dneg_s9;
		coll_s10 <= coll_s9;
		dm_s10   <= dm_s9;
		mx_s10 <= mx_s9; my_s10 <= my_s9;
	end

	// ------------------------------------------------------------------
	// Restoring divider, one quotient bit per stage for each axis
	// ------------------------------------------------------------------
	logic [NMW-1:0] remx_sdv [0:QB], remy_sdv [0:QB];
	logic [QB-1:0]  qx_sdv [0:QB], qy_sdv [0:QB];
	logic [DMW-1:0] dm_sdv [0:QB];
	dv_side_t       side_sdv [0:QB];

	logic [CMPW-1:0] trial_dv [1:QB];
	logic            gex_dv [1:QB], gey_dv [1:QB];

	always_comb begin
		for (int k = 1; k <= QB; k++) begin
			trial_dv[k] = CMPW'(dm_sdv[k-1]) << (QB - k);
			gex_dv[k]   = CMPW'(remx_sdv[k-1]) >= trial_dv[k];
			gey_dv[k]   = CMPW'(remy_sdv[k-1]) >= trial_dv[k];
		end
	end

	always_ff @(posedge clk) begin
		// load the first divider stage and flag quotients too large for the divider's range
		remx_sdv[0] <= nmx_s10;
		remy_sdv[0] <= nmy_s10;
		qx_sdv[0]   <= '0;
		qy_sdv[0]   <= '0;
		dm_sdv[0]   <= dm_s10;
		side_sdv[0].coll <= coll_s10;
		side_sdv[0].negx <= negx_s10;
		side_sdv[0].negy <= negy_s10;
		side_sdv[0].ovfx <= CMPW'(nmx_s10) >= (CMPW'(dm_s10) << QB);
		side_sdv[0].ovfy <= CMPW'(nmy_s10) >= (CMPW'(dm_s10) << QB);
		side_sdv[0].mx   <= mx_s10;
		side_sdv[0].my   <= my_s10;

		for (int k = 1; k <= QB; k++) begin
			remx_sdv[k] <= gex_dv[k] ? NMW'(CMPW'(remx_sdv[k-1]) - trial_dv[k])
			                         : remx_sdv[k-1];
			remy_sdv[k] <= gey_dv[k] ? NMW'(CMPW'(remy_sdv[k-1]) - trial_dv[k])
			                         : remy_sdv[k-1];
			qx_sdv[k]   <= qx_sdv[k-1] | (QB'(gex_dv[k]) << (QB - k));
			qy_sdv[k]   <= qy_sdv[k-1] | (QB'(gey_dv[k]) << (QB - k));
			dm_sdv[k]   <= dm_sdv[k-1];
			side_sdv[k] <= side_sdv[k-1];
		end
	end

	// ------------------------------------------------------------------
	// Round, place the centre, square the offsets, clamp
	// ------------------------------------------------------------------
	logic [QW-1:0]         qx_sr, qy_sr;
	dv_side_t              side_sr;
	logic signed [CXW-1:0] cenx_sc, ceny_sc;
	logic                  bigx_sc, bigy_sc;
	logic [2*OW-1:0]       sqx_sc, sqy_sc;
	dv_side_t              side_sc;

	logic signed [CXW-1:0] cenx_c, ceny_c;
	logic                  satx_c, saty_c;

	always_ff @(posedge clk) begin
		// ties round away from zero: bump when twice the remainder reaches the divisor
		qx_sr <= QW'(qx_sdv[QB]) +
		         QW'({remx_sdv[QB], 1'b0} >= (NMW+1)'(dm_sdv[QB]));
		qy_sr <= QW'(qy_sdv[QB]) +
		         QW'({remy_sdv[QB], 1'b0} >= (NMW+1)'(dm_sdv[QB]));
		side_sr <= side_sdv[QB];

		cenx_sc <= side_sr.negx ? CXW'(side_sr.mx) - $signed({2'b00, qx_sr})
		                        : CXW'(side_sr.mx) + $signed({2'b00, qx_sr});
		ceny_sc <= side_sr.negy ? CXW'(side_sr.my) - $signed({2'b00, qy_sr})
		                        : CXW'(side_sr.my) + $signed({2'b00, qy_sr});
		bigx_sc <= side_sr.ovfx || (qx_sr > OUT_MAX_Q);
		bigy_sc <= side_sr.ovfy || (qy_sr > OUT_MAX_Q);
		sqx_sc  <= qx_sr[OW-1:0] * qx_sr[OW-1:0];
		sqy_sc  <= qy_sr[OW-1:0] * qy_sr[OW-1:0];
		side_sc <= side_sr;
	end

	// An overflowed quotient is far beyond the range, so only its sign counts.
	always_comb begin
		satx_c = 1'b1;
		if (side_sc.ovfx) begin
			cenx_c = side_sc.negx ? SAT_NEG : SAT_POS;
		end else if (cenx_sc > SAT_POS) begin
			cenx_c = SAT_POS;
		end else if (cenx_sc < SAT_NEG) begin
			cenx_c = SAT_NEG;
		end else begin
			cenx_c = cenx_sc;
			satx_c = 1'b0;
		end
		saty_c = 1'b1;
		if (side_sc.ovfy) begin
			ceny_c = side_sc.negy ? SAT_NEG : SAT_POS;
		end else if (ceny_sc > SAT_POS) begin
			ceny_c = SAT_POS;
		end else if (ceny_sc < SAT_NEG) begin
			ceny_c = SAT_NEG;
		end else begin
			ceny_c = ceny_sc;
			saty_c = 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// Root extraction, one root bit per stage
	// ------------------------------------------------------------------
	logic [TW-1:0] rem_ssq [0:RB];
	logic [RB-1:0] root_ssq [0:RB];
	sq_side_t      side_ssq [0:RB];

	logic [TW-1:0] trial_sq [1:RB];
	logic          ge_sq [1:RB];

	always_comb begin
		for (int k = 1; k <= RB; k++) begin
			trial_sq[k] = (TW'(root_ssq[k-1]) << (RB - k + 1)) + (TW'(1) << (2 * (RB - k)));
			ge_sq[k]    = rem_ssq[k-1] >= trial_sq[k];
		end
	end

	always_ff @(posedge clk) begin
		rem_ssq[0]         <= TW'(sqx_sc) + TW'(sqy_sc);
		root_ssq[0]        <= '0;
		side_ssq[0].coll   <= side_sc.coll;
		side_ssq[0].satc   <= satx_c || saty_c;
		side_ssq[0].radsat <= bigx_sc || bigy_sc;
		side_ssq[0].cenx   <= OW'(cenx_c);
		side_ssq[0].ceny   <= OW'(ceny_c);

		for (int k = 1; k <= RB; k++) begin
			rem_ssq[k]  <= ge_sq[k] ? rem_ssq[k-1] - trial_sq[k] : rem_ssq[k-1];
			root_ssq[k] <= root_ssq[k-1] | (RB'(ge_sq[k]) << (RB - k));
			side_ssq[k] <= side_ssq[k-1];
		end
	end

	// ------------------------------------------------------------------
	// Output register: round and clamp the root, drop collinear triplets to zero
	// ------------------------------------------------------------------
	logic [RB:0] rad_c;
	logic        out_coll_q;

	assign rad_c = (RB+1)'(root_ssq[RB]) +
	               (RB+1)'(rem_ssq[RB] > TW'(root_ssq[RB]));

	always_ff @(posedge clk) begin
		out_coll_q <= side_ssq[RB].coll;
		if (side_ssq[RB].coll) begin
			center_x  <= '0;
			center_y  <= '0;
			radius    <= '0;
			valid_res <= 1'b0;
		end else begin
			center_x  <= side_ssq[RB].cenx;
			center_y  <= side_ssq[RB].ceny;
			if (side_ssq[RB].radsat || (rad_c > OUT_MAX_R)) begin
				radius <= '1;
			end else begin
				radius <= OW'(rad_c);
			end
			valid_res <= !(side_ssq[RB].satc || side_ssq[RB].radsat ||
			               (rad_c > OUT_MAX_R));
		end
	end

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	`ASSERT_NEXT(a_done_follows_root, clk, arst_n, 1'b1, done == $past(vld_ssq[RB]), "done strobe out of step with the root stages")
	`ASSERT_SAME(a_coll_zero, clk, arst_n, done && out_coll_q, center_x == '0 && center_y == '0 && radius == '0 && !valid_res, "collinear word not cleared")

endmodule
